// ----- hdl/mtbl_pkg.sv -----
// ----------------------------------------------------------------------------
// mtbl_pkg
// Shared constants, types and helpers of the bilinear map lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtbl_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;

    // axis storage is sized for the larger of the two axes
    localparam int AX_N    = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int AX_IW   = $clog2(AX_N);
    localparam int CELL_N  = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_AW = $clog2(CELL_N);

    localparam int VAL_W = 16;
    localparam int DEN_W = 2 * VAL_W;
    localparam int NUM_W = 3 * VAL_W;
    localparam int FRAC_W = 8;
    localparam int Q_W   = VAL_W + FRAC_W;

    // transaction modes
    localparam logic [1:0] MODE_COL_BIN = 2'd0;
    localparam logic [1:0] MODE_ROW_BIN = 2'd1;
    localparam logic [1:0] MODE_CELL    = 2'd2;
    localparam logic [1:0] MODE_LOOKUP  = 2'd3;

    // register indexes (paddr bit 2)
    localparam logic REG_COLUMNS_USED = 1'b0;
    localparam logic REG_ROWS_USED    = 1'b1;

    localparam logic [4:0] COUNT_RESET = 5'd16;

    typedef logic [AX_IW-1:0]   t_ax_idx;
    typedef logic [CELL_AW-1:0] t_cell_addr;
    typedef logic [VAL_W-1:0]   t_val;

    typedef struct packed {
        logic    wr;
        t_ax_idx widx;
        t_val    wval;
        t_val    point;
        t_ax_idx last;
    } t_axis_req;

    typedef struct packed {
        t_ax_idx idx;
        t_val    width;
        t_val    offset;
    } t_axis_res;

    typedef struct packed {
        t_val wx;
        t_val dx;
        t_val wy;
        t_val dy;
    } t_blend_wt;

    // index of the last bin in use, with the count held to 2..maxn
    function automatic t_ax_idx last_index(input logic [4:0] cfg, input int maxn);
        int n;
        n = int'(cfg);
        if (n < 2) begin
            n = 2;
        end
        if (n > maxn) begin
            n = maxn;
        end
        return t_ax_idx'(n - 1);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mtbl_ram.sv -----
// ----------------------------------------------------------------------------
// mtbl_ram
// Generic single write, single read RAM with registered read-first output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/mtbl_axis.sv -----
// ----------------------------------------------------------------------------
// mtbl_axis
// One axis: bin storage, point clamp, bin search, bin width and offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtbl_axis (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire mtbl_pkg::t_axis_req i_req,
    output mtbl_pkg::t_axis_res      o_res
);
    import mtbl_pkg::*;

    t_val      r_ax [AX_N];
    t_val      r_a_p;
    t_ax_idx   r_a_last;
    t_val      r_b_p;
    t_ax_idx   r_b_idx;
    t_axis_res r_c;

    t_val      n_a_p;
    t_ax_idx   n_idx;
    logic      found;
    t_val      lo_val;
    t_val      hi_val;
    t_axis_res n_c;

    // bins are written in the slot of the write transaction
    always_ff @(posedge i_clk) begin
        if (i_en && i_req.wr) begin
            r_ax[i_req.widx] <= i_req.wval;
        end
    end

    // clamp to the first and last bin in use
    always_comb begin
        n_a_p = i_req.point;
        if (n_a_p < r_ax[0]) begin
            n_a_p = r_ax[0];
        end
        if (n_a_p > r_ax[i_req.last]) begin
            n_a_p = r_ax[i_req.last];
        end
    end

    // first bin whose upper edge is at or above the point
    always_comb begin
        n_idx = t_ax_idx'(r_a_last - 1'b1);
        found = 1'b0;
        for (int i = 0; i < AX_N - 1; i++) begin
            if (!found && (t_ax_idx'(i) < r_a_last) && (r_a_p <= r_ax[i + 1])) begin
                n_idx = t_ax_idx'(i);
                found = 1'b1;
            end
        end
    end

    mtbl_ram #(.WIDTH(VAL_W), .DEPTH(AX_N)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (i_en && i_req.wr),
        .i_waddr (i_req.widx),
        .i_wdata (i_req.wval),
        .i_re    (i_en),
        .i_raddr (n_idx),
        .o_rdata (lo_val)
    );

    mtbl_ram #(.WIDTH(VAL_W), .DEPTH(AX_N)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (i_en && i_req.wr),
        .i_waddr (i_req.widx),
        .i_wdata (i_req.wval),
        .i_re    (i_en),
        .i_raddr (t_ax_idx'(n_idx + 1'b1)),
        .o_rdata (hi_val)
    );

    // bin width and offset, zero-width bin falls back to the lower value
    always_comb begin
        n_c.idx = r_b_idx;
        if (hi_val <= lo_val) begin
            n_c.width  = t_val'(1);
            n_c.offset = '0;
        end else begin
            n_c.width = hi_val - lo_val;
            if (r_b_p <= lo_val) begin
                n_c.offset = '0;
            end else if (r_b_p >= hi_val) begin
                n_c.offset = hi_val - lo_val;
            end else begin
                n_c.offset = r_b_p - lo_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p    <= n_a_p;
            r_a_last <= i_req.last;
            r_b_p    <= r_a_p;
            r_b_idx  <= n_idx;
            r_c      <= n_c;
        end
    end

    assign o_res = r_c;

endmodule

`default_nettype wire

// ----- hdl/mtbl_blend.sv -----
// ----------------------------------------------------------------------------
// mtbl_blend
// Weighted sum of the four corner cells and the denominator, four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtbl_blend (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire mtbl_pkg::t_val        i_z11,
    input  wire mtbl_pkg::t_val        i_z21,
    input  wire mtbl_pkg::t_val        i_z12,
    input  wire mtbl_pkg::t_val        i_z22,
    input  wire mtbl_pkg::t_blend_wt   i_wt,
    output logic                       o_valid,
    output logic [mtbl_pkg::NUM_W-1:0] o_num,
    output logic [mtbl_pkg::DEN_W-1:0] o_den
);
    import mtbl_pkg::*;

    logic             r_e_v, r_f_v, r_g_v, r_h_v;
    logic [DEN_W-1:0] r_p11, r_p21, r_p12, r_p22;
    t_val             r_e_ay, r_e_dy, r_f_ay, r_f_dy;
    logic [DEN_W-1:0] r_lon, r_hin;
    logic [NUM_W-1:0] r_m1, r_m2, r_num;
    logic [DEN_W-1:0] r_e_den, r_f_den, r_g_den, r_h_den;

    t_val ax;

    assign ax = i_wt.wx - i_wt.dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= i_valid;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // along the columns
            r_p11   <= i_z11 * ax;
            r_p21   <= i_z21 * i_wt.dx;
            r_p12   <= i_z12 * ax;
            r_p22   <= i_z22 * i_wt.dx;
            r_e_ay  <= i_wt.wy - i_wt.dy;
            r_e_dy  <= i_wt.dy;
            r_e_den <= i_wt.wx * i_wt.wy;
            // lower and upper row sums stay below 2^32
            r_lon   <= r_p11 + r_p21;
            r_hin   <= r_p12 + r_p22;
            r_f_ay  <= r_e_ay;
            r_f_dy  <= r_e_dy;
            r_f_den <= r_e_den;
            // along the rows
            r_m1    <= r_lon * r_f_ay;
            r_m2    <= r_hin * r_f_dy;
            r_g_den <= r_f_den;
            r_num   <= r_m1 + r_m2;
            r_h_den <= r_g_den;
        end
    end

    assign o_valid = r_h_v;
    assign o_num   = r_num;
    assign o_den   = r_h_den;

endmodule

`default_nettype wire

// ----- hdl/mtbl_div.sv -----
// ----------------------------------------------------------------------------
// mtbl_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtbl_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire  [mtbl_pkg::NUM_W-1:0] i_num,
    input  wire  [mtbl_pkg::DEN_W-1:0] i_den,
    output logic                       o_valid,
    output logic [mtbl_pkg::Q_W-1:0]   o_quot
);
    import mtbl_pkg::*;

    // dividend is num scaled by 2^FRAC_W; the quotient fits Q_W bits, so the
    // top DEN_W dividend bits start below the divisor
    localparam int LOW_W = NUM_W + FRAC_W - DEN_W;

    logic             r_v   [Q_W];
    logic [DEN_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [LOW_W-1:0] r_low [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            logic             v_in;
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [LOW_W-1:0] low_in;
            logic [Q_W-1:0]   q_in;
            logic [DEN_W:0]   trial;
            logic             ge;

            if (g == 0) begin : g_first
                assign v_in   = i_valid;
                assign rem_in = i_num[NUM_W-1 -: DEN_W];
                assign den_in = i_den;
                assign low_in = {i_num[NUM_W-DEN_W-1:0], {FRAC_W{1'b0}}};
                assign q_in   = '0;
            end else begin : g_next
                assign v_in   = r_v[g-1];
                assign rem_in = r_rem[g-1];
                assign den_in = r_den[g-1];
                assign low_in = r_low[g-1];
                assign q_in   = r_q[g-1];
            end

            assign trial = {rem_in, low_in[LOW_W-1]};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                    r_den[g] <= den_in;
                    r_low[g] <= {low_in[LOW_W-2:0], 1'b0};
                    r_q[g]   <= {q_in[Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_q[Q_W-1];

endmodule

`default_nettype wire

// ----- hdl/map_table_bilinear_lookup.sv -----
// ----------------------------------------------------------------------------
// map_table_bilinear_lookup
// Two-dimensional calibration map with bilinear interpolation.
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_stall): each transaction carries a mode. column
//   bin, row bin and cell writes load the map and give no result; a lookup
//   gives one result on the output channel (o_valid / i_stall) with 8
//   fraction bits, truncated. bins and cells must be written before a lookup
//   reads them.
//   a lookup result reaches o_valid through the input register, three axis
//   stages (clamp, bin search, width and offset), cell read, four multiply and
//   add stages and a 24-stage divider that gives one quotient bit per stage.
//   throughput: one transaction per cycle unless a stalled result holds the
//   pipeline; reads and writes of the map stay in order because each write
//   lands in the stage where that store is read.
//   reset clears all valid bits and sets both bin counts to 16; map contents
//   are not cleared.
//   when the receiver stalls a waiting result, the whole pipeline holds and
//   o_stall is raised, nothing is lost or repeated.
//   config: APB registers columns_used at 0x0 and rows_used at 0x4. The user
//   must see that they are written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module map_table_bilinear_lookup (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_mode,
    input  wire  [3:0]  i_column_index,
    input  wire  [3:0]  i_row_index,
    input  wire  [15:0] i_write_value,
    input  wire  [15:0] i_point_x,
    input  wire  [15:0] i_point_y,
    // output channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic [23:0] o_interpolated_value,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mtbl_pkg::*;

    // configuration registers
    logic [4:0] r_columns_used;
    logic [4:0] r_rows_used;
    logic       cfg_wr;

    // pipeline control
    logic       w_en;
    logic       div_valid;

    // input register
    logic       r0_valid;
    logic [1:0] r0_mode;
    logic [3:0] r0_ci;
    logic [3:0] r0_ri;
    t_val       r0_wv;
    t_val       r0_px;
    t_val       r0_py;

    // write and lookup tracking through the axis stages
    logic       r_a_look, r_b_look, r_c_look;
    logic       r_a_cwr,  r_b_cwr,  r_c_cwr;
    t_cell_addr r_a_caddr, r_b_caddr, r_c_caddr;
    t_val       r_a_wv, r_b_wv, r_c_wv;

    t_axis_req  col_req, row_req;
    t_axis_res  col_res, row_res;
    logic       n_cwr;
    t_cell_addr n_caddr;

    // cell stage
    t_cell_addr a11, a21, a12, a22;
    t_val       z11, z21, z12, z22;
    logic       r_d_valid;
    t_blend_wt  r_d_wt;

    logic [NUM_W-1:0] blend_num;
    logic [DEN_W-1:0] blend_den;
    logic             blend_valid;

    // ------------------------------------------------------------------
    // configuration port, no wait states
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns_used <= COUNT_RESET;
            r_rows_used    <= COUNT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_COLUMNS_USED: r_columns_used <= pwdata[4:0];
                REG_ROWS_USED:    r_rows_used    <= pwdata[4:0];
                default:          r_columns_used <= r_columns_used;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_COLUMNS_USED: prdata = {27'd0, r_columns_used};
            REG_ROWS_USED:    prdata = {27'd0, r_rows_used};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline advances unless a finished result is held by the receiver
    // ------------------------------------------------------------------
    assign w_en    = !(div_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_mode <= i_mode;
            r0_ci   <= i_column_index;
            r0_ri   <= i_row_index;
            r0_wv   <= i_write_value;
            r0_px   <= i_point_x;
            r0_py   <= i_point_y;
        end
    end

    // ------------------------------------------------------------------
    // axis requests; bin writes beyond the axis size are dropped
    // ------------------------------------------------------------------
    always_comb begin
        col_req.wr    = r0_valid && (r0_mode == MODE_COL_BIN) && (int'(r0_ci) < MAX_COLUMNS);
        col_req.widx  = t_ax_idx'(r0_ci);
        col_req.wval  = r0_wv;
        col_req.point = r0_px;
        col_req.last  = last_index(r_columns_used, MAX_COLUMNS);

        row_req.wr    = r0_valid && (r0_mode == MODE_ROW_BIN) && (int'(r0_ri) < MAX_ROWS);
        row_req.widx  = t_ax_idx'(r0_ri);
        row_req.wval  = r0_wv;
        row_req.point = r0_py;
        row_req.last  = last_index(r_rows_used, MAX_ROWS);
    end

    mtbl_axis u_col_axis (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_req (col_req),
        .o_res (col_res)
    );

    mtbl_axis u_row_axis (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_req (row_req),
        .o_res (row_res)
    );

    // cell writes travel with the axis stages and land where cells are read
    assign n_cwr   = r0_valid && (r0_mode == MODE_CELL)
                  && (int'(r0_ci) < MAX_COLUMNS) && (int'(r0_ri) < MAX_ROWS);
    assign n_caddr = t_cell_addr'(int'(r0_ri) * MAX_COLUMNS + int'(r0_ci));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_look <= 1'b0;
            r_b_look <= 1'b0;
            r_c_look <= 1'b0;
            r_a_cwr  <= 1'b0;
            r_b_cwr  <= 1'b0;
            r_c_cwr  <= 1'b0;
        end else if (w_en) begin
            r_a_look <= r0_valid && (r0_mode == MODE_LOOKUP);
            r_b_look <= r_a_look;
            r_c_look <= r_b_look;
            r_a_cwr  <= n_cwr;
            r_b_cwr  <= r_a_cwr;
            r_c_cwr  <= r_b_cwr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_caddr <= n_caddr;
            r_b_caddr <= r_a_caddr;
            r_c_caddr <= r_b_caddr;
            r_a_wv    <= r0_wv;
            r_b_wv    <= r_a_wv;
            r_c_wv    <= r_b_wv;
        end
    end

    // ------------------------------------------------------------------
    // four corner reads, one cell copy per corner
    // ------------------------------------------------------------------
    assign a11 = t_cell_addr'(int'(row_res.idx) * MAX_COLUMNS + int'(col_res.idx));
    assign a21 = t_cell_addr'(int'(row_res.idx) * MAX_COLUMNS + int'(col_res.idx) + 1);
    assign a12 = t_cell_addr'((int'(row_res.idx) + 1) * MAX_COLUMNS + int'(col_res.idx));
    assign a22 = t_cell_addr'((int'(row_res.idx) + 1) * MAX_COLUMNS + int'(col_res.idx) + 1);

    mtbl_ram #(.WIDTH(VAL_W), .DEPTH(CELL_N)) u_cell11 (
        .i_clk (i_clk), .i_we (w_en && r_c_cwr), .i_waddr (r_c_caddr),
        .i_wdata (r_c_wv), .i_re (w_en), .i_raddr (a11), .o_rdata (z11)
    );

    mtbl_ram #(.WIDTH(VAL_W), .DEPTH(CELL_N)) u_cell21 (
        .i_clk (i_clk), .i_we (w_en && r_c_cwr), .i_waddr (r_c_caddr),
        .i_wdata (r_c_wv), .i_re (w_en), .i_raddr (a21), .o_rdata (z21)
    );

    mtbl_ram #(.WIDTH(VAL_W), .DEPTH(CELL_N)) u_cell12 (
        .i_clk (i_clk), .i_we (w_en && r_c_cwr), .i_waddr (r_c_caddr),
        .i_wdata (r_c_wv), .i_re (w_en), .i_raddr (a12), .o_rdata (z12)
    );

    mtbl_ram #(.WIDTH(VAL_W), .DEPTH(CELL_N)) u_cell22 (
        .i_clk (i_clk), .i_we (w_en && r_c_cwr), .i_waddr (r_c_caddr),
        .i_wdata (r_c_wv), .i_re (w_en), .i_raddr (a22), .o_rdata (z22)
    );

    // weights line up with the registered cell data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_look;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_wt.wx <= col_res.width;
            r_d_wt.dx <= col_res.offset;
            r_d_wt.wy <= row_res.width;
            r_d_wt.dy <= row_res.offset;
        end
    end

    // ------------------------------------------------------------------
    // weighted sum, then division by the bin area
    // ------------------------------------------------------------------
    mtbl_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_valid),
        .i_z11   (z11),
        .i_z21   (z21),
        .i_z12   (z12),
        .i_z22   (z22),
        .i_wt    (r_d_wt),
        .o_valid (blend_valid),
        .o_num   (blend_num),
        .o_den   (blend_den)
    );

    // last divider stage is the output register
    mtbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (blend_valid),
        .i_num   (blend_num),
        .i_den   (blend_den),
        .o_valid (div_valid),
        .o_quot  (o_interpolated_value)
    );

    assign o_valid = div_valid;

endmodule

`default_nettype wire

// ----- hdl/mtbl_checker.sv -----
// ----------------------------------------------------------------------------
// mtbl_checker
// Port-level checks of the bilinear map lookup, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtbl_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [23:0] o_interpolated_value,
    input wire        psel,
    input wire        penable,
    input wire        pwrite,
    input wire [2:0]  paddr,
    input wire [31:0] pwdata,
    input wire [31:0] prdata
);

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_interpolated_value)))
        else $error("stalled result changed");

    // input side only waits behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without a held result");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

    // a column count write reads back
    a_cfg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[2] ##1 !paddr[2])
        |-> (prdata[4:0] == $past(pwdata[4:0])))
        else $error("columns_used readback mismatch");

endmodule

bind map_table_bilinear_lookup mtbl_checker u_mtbl_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_stall              (o_stall),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_interpolated_value (o_interpolated_value),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata)
);

`default_nettype wire
